[hw/rtl/cma_pkg.sv]
// Shared constants for the centered moving average block.
`timescale 1ns / 1ps

package cma_pkg;

    // Fraction bits of the mean (Q.8)
    localparam int FRAC_BITS = 8;

    // Configuration register file
    localparam int WS_W            = 7;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;
    localparam int REG_WINDOW_SIZE = 0;
    localparam logic [WS_W-1:0] WS_RESET = 7'd1;

endpackage

[hw/rtl/cma_if.sv]
// Stream interfaces for samples in and averages out.
`timescale 1ns / 1ps

interface cma_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_waveform;

    modport source (output valid, output sample, output end_of_waveform, input ready);
    modport sink   (input valid, input sample, input end_of_waveform, output ready);
endinterface

interface cma_out_if #(parameter int AVG_BITS = 24);
    logic                       valid;
    logic                       ready;
    logic signed [AVG_BITS-1:0] average;
    logic                       end_of_output;

    modport source (output valid, output average, output end_of_output, input ready);
    modport sink   (input valid, input average, input end_of_output, output ready);
endinterface

[hw/rtl/cma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/cma_div.sv]
// Bit-serial signed-by-unsigned divider, truncating toward zero.
`timescale 1ns / 1ps

module cma_div #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic        [DEN_W-1:0] den,
    output logic                    done,
    output logic signed [NUM_W-1:0] quot
);

    localparam int ITER_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  q_reg,    q_next;
    logic [DEN_W:0]    rem_reg,  rem_next;
    logic [DEN_W-1:0]  den_reg,  den_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              neg_reg,  neg_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DEN_W:0]    rem_sh;
    logic              ge;

    // shift in next dividend bit, restore if below divisor
    assign rem_sh = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        iter_next = iter_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            neg_next  = num[NUM_W-1];
            q_next    = num[NUM_W-1] ? (~num + 1'b1) : num;
            rem_next  = '0;
            den_next  = den;
            iter_next = ITER_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            q_next    = {q_reg[NUM_W-2:0], ge};
            iter_next = iter_reg - 1'b1;
            if (iter_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            iter_reg <= iter_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

[hw/rtl/centered_moving_average.sv]
// Centered moving average with truncated edges, Q.8 mean per position.
// Per sample: the sample leaving the window is read, the new one written and the
//   sum updated, then the bit-serial divider forms a mean (one quotient bit per cycle).
//   Each flushed position trims the window with one read per dropped sample. A new sample
//   is taken only in idle, once the last one, its output and any flush it starts are done.
// Reset: rst_n is asynchronous active low; window_size returns to 1, the running sum,
//   sample count and ring pointer clear. The sample RAM is not cleared.
`timescale 1ns / 1ps

module centered_moving_average
    import cma_pkg::*;
#(
    parameter int MAX_HALF    = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    cma_in_if.sink                sample_ch,
    cma_out_if.source             result_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Ring of the last 2*MAX_HALF+1 samples
    localparam int DEPTH  = 2 * MAX_HALF + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int HW     = $clog2(MAX_HALF + 1);
    localparam int PW     = CNT_W + 1;
    // Sum of DEPTH samples fits in SAMPLE_BITS + clog2(DEPTH) signed bits
    localparam int SUM_W  = SAMPLE_BITS + $clog2(DEPTH);
    localparam int NUM_W  = SUM_W + FRAC_BITS;
    localparam int AVG_W  = SAMPLE_BITS + FRAC_BITS;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;  // read sample leaving the window
    localparam logic [3:0] S_ADD   = 4'd2;  // write new sample, update sum
    localparam logic [3:0] S_DIVGO = 4'd3;
    localparam logic [3:0] S_DIVW  = 4'd4;
    localparam logic [3:0] S_EMIT  = 4'd5;
    localparam logic [3:0] S_FNEXT = 4'd6;  // pick next flush position
    localparam logic [3:0] S_FTRIM = 4'd7;  // shrink window toward its target
    localparam logic [3:0] S_FSUB  = 4'd8;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [WS_W-1:0] ws_reg;
    logic            reg_sel;

    // word index = paddr[2]; only index 0 exists
    assign reg_sel = (paddr[APB_ADDR_W-1] == 1'(REG_WINDOW_SIZE));
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(APB_DATA_W-WS_W){1'b0}}, ws_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= WS_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            ws_reg <= pwdata[WS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Datapath / sequencer registers
    // ------------------------------------------------------------------
    logic [3:0]                    state_reg, state_next;
    logic [HW-1:0]                 h_reg,     h_next;     // half width of this waveform
    logic [HW-1:0]                 d_reg,     d_next;     // flush distance countdown
    logic signed [SAMPLE_BITS-1:0] x_reg,     x_next;
    logic                          last_reg,  last_next;
    logic                          sub_reg,   sub_next;
    logic signed [SUM_W-1:0]       sum_reg,   sum_next;
    logic [CNT_W-1:0]              cnt_reg,   cnt_next;   // samples seen, saturating
    logic [CNT_W-1:0]              cur_reg,   cur_next;   // samples in current window
    logic [CNT_W-1:0]              tgt_reg,   tgt_next;
    logic [ADDR_W-1:0]             wp_reg,    wp_next;
    logic                          ov_reg,    ov_next;
    logic signed [AVG_W-1:0]       avg_reg,   avg_next;
    logic                          eoo_reg,   eoo_next;

    // RAM and divider hookup
    logic                          ram_we, ram_re;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic                          div_start, div_done;
    logic signed [NUM_W-1:0]       div_num, div_quot;

    // helper terms
    logic [CNT_W-1:0]              span;
    logic [CNT_W-1:0]              n_new, cur_new;
    logic signed [SUM_W-1:0]       x_ext, rd_ext;
    logic [HW-1:0]                 h_cfg, d_dec;
    logic [CNT_W-1:0]              tgt_raw;
    logic [CNT_W-1:0]              ring_k;
    logic [PW-1:0]                 ring_tmp;
    logic                          out_free;

    assign span     = (CNT_W'(h_reg) << 1) + 1'b1;
    assign n_new    = (cnt_reg == CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cnt_reg + 1'b1;
    assign cur_new  = (n_new < span) ? n_new : span;
    assign x_ext    = SUM_W'(x_reg);
    assign rd_ext   = SUM_W'($signed(ram_rdata));
    assign h_cfg    = ((32'(ws_reg) >> 1) > 32'(MAX_HALF)) ? HW'(MAX_HALF)
                                                           : HW'(ws_reg >> 1);
    assign d_dec    = d_reg - 1'b1;
    assign tgt_raw  = CNT_W'(d_dec) + CNT_W'(h_reg) + 1'b1;
    assign out_free = !ov_reg || result_ch.ready;

    // slot of the sample k places back from the write pointer (k = 1 .. DEPTH)
    assign ring_k   = (state_reg == S_LOAD) ? span : cur_reg;
    assign ring_tmp = PW'(wp_reg) + PW'(DEPTH) - PW'(ring_k);
    assign ram_raddr = (ring_tmp >= PW'(DEPTH)) ? ADDR_W'(ring_tmp - PW'(DEPTH))
                                                : ADDR_W'(ring_tmp);

    assign div_num  = {sum_reg, {FRAC_BITS{1'b0}}};

    always_comb
    begin
        state_next = state_reg;
        h_next     = h_reg;
        d_next     = d_reg;
        x_next     = x_reg;
        last_next  = last_reg;
        sub_next   = sub_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        tgt_next   = tgt_reg;
        wp_next    = wp_reg;
        ov_next    = ov_reg && !result_ch.ready;
        avg_next   = avg_reg;
        eoo_next   = eoo_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        div_start  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (sample_ch.valid)
                begin
                    x_next    = sample_ch.sample;
                    last_next = sample_ch.end_of_waveform;
                    // half width latches on a waveform's first sample
                    if (cnt_reg == '0)
                    begin
                        h_next = h_cfg;
                        d_next = h_cfg;
                    end
                    else
                    begin
                        d_next = h_reg;
                    end
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                // oldest sample drops out once the full window is populated
                ram_re     = 1'b1;
                sub_next   = (cnt_reg >= span);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                ram_we   = 1'b1;
                sum_next = sum_reg + x_ext - (sub_reg ? rd_ext : '0);
                wp_next  = (wp_reg == ADDR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                cnt_next = n_new;
                cur_next = cur_new;
                if (n_new > CNT_W'(h_reg))
                begin
                    state_next = S_DIVGO;
                end
                else if (last_reg)
                begin
                    state_next = S_FNEXT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    avg_next   = div_quot[AVG_W-1:0];
                    // final position of the waveform is the last flush step
                    eoo_next   = last_reg && (d_reg == '0);
                    state_next = last_reg ? S_FNEXT : S_IDLE;
                end
            end
            S_FNEXT:
            begin
                if (d_reg == '0)
                begin
                    // waveform done: clear sum, count and ring pointer
                    sum_next   = '0;
                    cnt_next   = '0;
                    wp_next    = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    d_next = d_dec;
                    // positions beyond a short waveform are skipped
                    if (CNT_W'(d_dec) < cnt_reg)
                    begin
                        tgt_next   = (tgt_raw > cnt_reg) ? cnt_reg : tgt_raw;
                        state_next = S_FTRIM;
                    end
                end
            end
            S_FTRIM:
            begin
                if (cur_reg > tgt_reg)
                begin
                    // read age cur-1, i.e. cur slots behind the write pointer
                    ram_re     = 1'b1;
                    cur_next   = cur_reg - 1'b1;
                    state_next = S_FSUB;
                end
                else
                begin
                    state_next = S_DIVGO;
                end
            end
            S_FSUB:
            begin
                sum_next   = sum_reg - rd_ext;
                state_next = S_FTRIM;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            h_reg     <= '0;
            d_reg     <= '0;
            last_reg  <= 1'b0;
            sub_reg   <= 1'b0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            cur_reg   <= '0;
            wp_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            h_reg     <= h_next;
            d_reg     <= d_next;
            last_reg  <= last_next;
            sub_reg   <= sub_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            cur_reg   <= cur_next;
            wp_reg    <= wp_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        tgt_reg <= tgt_next;
        avg_reg <= avg_next;
        eoo_reg <= eoo_next;
    end

    assign sample_ch.ready       = (state_reg == S_IDLE);
    assign result_ch.valid       = ov_reg;
    assign result_ch.average     = avg_reg;
    assign result_ch.end_of_output = eoo_reg;

    // ------------------------------------------------------------------
    // Sample ring and shared divider
    // ------------------------------------------------------------------
    cma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (x_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cma_div #(
        .NUM_W (NUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (cur_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

endmodule
